// ----- hdl/caes_pkg.sv -----
// Shared constants, codes and helper functions for the auto-exposure stepper.
// No dependencies; imported by camera_auto_exposure_stepper_core.
`timescale 1ns / 1ps
`default_nettype none

package caes_pkg;

    // Averaging windows, in frames (each 1 to 4)
    localparam int unsigned FAST_WINDOW = 4;
    localparam int unsigned SLOW_WINDOW = 2;

    localparam int unsigned STEP_SMALL   = 1;
    localparam int unsigned STEP_BIG     = 3;
    localparam int unsigned LEVEL_FLOOR  = 1;
    localparam int unsigned LEVEL_TOP    = 82;
    localparam int unsigned BOUND_A      = 19;
    localparam int unsigned BOUND_B      = 40;
    localparam int unsigned BOUND_C      = 61;
    localparam int unsigned START_LEVEL  = 16;
    localparam int unsigned START_GAIN   = 2;

    localparam logic [7:0] RST_LEVEL_DARK  = 8'd30;
    localparam logic [7:0] RST_LEVEL_LOW   = 8'd60;
    localparam logic [7:0] RST_LEVEL_HIGH  = 8'd120;
    localparam logic [7:0] RST_LEVEL_SHINY = 8'd180;

    typedef enum logic [2:0] {
        REG_LEVEL_DARK  = 3'd0,
        REG_LEVEL_LOW   = 3'd1,
        REG_LEVEL_HIGH  = 3'd2,
        REG_LEVEL_SHINY = 3'd3,
        REG_HIGH_SPEED  = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BAND_NONE      = 3'd0,
        BAND_OPTIMAL   = 3'd1,
        BAND_BELOW     = 3'd2,
        BAND_ABOVE     = 3'd3,
        BAND_TOO_LOW   = 3'd4,
        BAND_TOO_HIGH  = 3'd5,
        BAND_UNMATCHED = 3'd6
    } band_t;

    typedef struct packed {
        logic       changed;
        logic [6:0] level;
        logic [2:0] gain;
    } step_t;

    // Divide the window sum by a constant window of 1 to 4 frames.
    // For 3, floor(x * 683 / 2048) equals floor(x / 3) over all 10-bit x.
    function automatic logic [9:0] div_window(input logic [9:0] sum, input int unsigned win);
        logic [20:0] prod;
        prod = {11'd0, sum} * 21'd683;
        case (win)
            1:       return sum;
            2:       return {1'b0, sum[9:1]};
            3:       return prod[20:11];
            default: return {2'b00, sum[9:2]};
        endcase
    endfunction

    function automatic step_t step_up(input logic [6:0] old, input logic [2:0] gain,
                                      input int unsigned step);
        logic [7:0] raw;
        logic [6:0] nw;
        step_t      r;
        raw = {1'b0, old} + 8'(step);
        nw  = (raw > 8'(LEVEL_TOP)) ? 7'(LEVEL_TOP) : raw[6:0];
        r.changed = (nw > old);
        r.level   = r.changed ? nw : old;
        r.gain    = gain;
        if (r.changed)
        begin
            if (nw > 7'(BOUND_C) && old <= 7'(BOUND_C))
                r.gain = 3'd4;
            else if (nw > 7'(BOUND_B) && old <= 7'(BOUND_B))
                r.gain = 3'd3;
            else if (nw > 7'(BOUND_A) && old <= 7'(BOUND_A))
                r.gain = 3'd2;
        end
        return r;
    endfunction

    // Downward crossing of the top bound leaves the gain alone.
    function automatic step_t step_down(input logic [6:0] old, input logic [2:0] gain,
                                        input int unsigned step);
        logic [6:0] nw;
        step_t      r;
        nw = ({1'b0, old} >= 8'(LEVEL_FLOOR + step)) ? (old - 7'(step)) : 7'(LEVEL_FLOOR);
        r.changed = (nw < old);
        r.level   = r.changed ? nw : old;
        r.gain    = gain;
        if (r.changed)
        begin
            if (nw <= 7'(BOUND_B) && old > 7'(BOUND_B))
                r.gain = 3'd3;
            else if (nw <= 7'(BOUND_A) && old > 7'(BOUND_A))
                r.gain = 3'd2;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/camera_auto_exposure_stepper_core.sv -----
// Auto-exposure stepper: frame windowing, band sort, LED level and gain update.
// Depends on caes_pkg (constants, band codes, divide and step functions).
`timescale 1ns / 1ps
`default_nettype none

//  channel | signals                                          | beat
//  --------+--------------------------------------------------+--------------------------
//  cfg     | cfg_valid cfg_ready cfg_index[2:0] cfg_data[7:0] | one register write
//  in      | in_valid in_ready action patch_mean eyelid_covered | one frame or restart
//  out     | out_valid out_ready led_level digital_gain ...    | one result per input beat
//
//  One item a cycle unless the output stalls: state updates at the input beat, and
//  the result appears in the output register on the next cycle.
//  in_ready is high while the output register is empty or being drained.
//  A stalled result holds; the state has already moved on, so nothing is recomputed.
//  Reset loads the register defaults, level 16, gain 2, and clears the window.

module camera_auto_exposure_stepper_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire logic [7:0]             patch_mean,
    input  wire logic                   eyelid_covered,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [6:0]                  led_level,
    output logic [2:0]                  digital_gain,
    output logic                        average_ready,
    output logic [7:0]                  frame_average,
    output caes_pkg::band_t             band,
    output logic                        level_changed
);
    import caes_pkg::*;

    localparam logic [2:0] WIN_FAST = 3'(FAST_WINDOW);
    localparam logic [2:0] WIN_SLOW = 3'(SLOW_WINDOW);

    logic [7:0] level_dark_reg, level_low_reg, level_high_reg, level_shiny_reg;
    logic       high_speed_reg;

    logic [9:0] mean_sum_reg, mean_sum_next;
    logic [2:0] frame_count_reg, frame_count_next;
    logic [6:0] light_level_reg, light_level_next;
    logic [2:0] gain_factor_reg, gain_factor_next;
    logic [7:0] last_average_reg, last_average_next;

    logic       out_valid_reg;
    logic [6:0] led_level_reg;
    logic [2:0] digital_gain_reg;
    logic       average_ready_reg, average_ready_next;
    logic [7:0] frame_average_reg;
    band_t      band_reg, band_next;
    logic       level_changed_reg, level_changed_next;

    logic       in_beat;
    logic [2:0] window;
    logic [2:0] count_inc;
    logic [9:0] avg;
    logic [9:0] dark_w, low_w, high_w, shiny_w;
    step_t      step_r;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_dark_reg  <= RST_LEVEL_DARK;
            level_low_reg   <= RST_LEVEL_LOW;
            level_high_reg  <= RST_LEVEL_HIGH;
            level_shiny_reg <= RST_LEVEL_SHINY;
            high_speed_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEVEL_DARK:  level_dark_reg  <= cfg_data;
                REG_LEVEL_LOW:   level_low_reg   <= cfg_data;
                REG_LEVEL_HIGH:  level_high_reg  <= cfg_data;
                REG_LEVEL_SHINY: level_shiny_reg <= cfg_data;
                REG_HIGH_SPEED:  high_speed_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign window    = high_speed_reg ? WIN_FAST : WIN_SLOW;
    assign count_inc = frame_count_reg + 3'd1;
    assign dark_w    = {2'b00, level_dark_reg};
    assign low_w     = {2'b00, level_low_reg};
    assign high_w    = {2'b00, level_high_reg};
    assign shiny_w   = {2'b00, level_shiny_reg};

    always_comb
    begin
        mean_sum_next      = mean_sum_reg;
        frame_count_next   = frame_count_reg;
        light_level_next   = light_level_reg;
        gain_factor_next   = gain_factor_reg;
        last_average_next  = last_average_reg;
        average_ready_next = 1'b0;
        band_next          = BAND_NONE;
        level_changed_next = 1'b0;
        step_r             = '{changed: 1'b0, level: light_level_reg, gain: gain_factor_reg};
        avg                = '0;

        if (action)
        begin
            light_level_next  = 7'(START_LEVEL);
            gain_factor_next  = 3'(START_GAIN);
            last_average_next = '0;
        end
        else if (eyelid_covered)
        begin
            frame_count_next = '0;
        end
        else
        begin
            // First frame of a window restarts the sum
            mean_sum_next    = (frame_count_reg == 3'd0) ? {2'b00, patch_mean}
                                                         : mean_sum_reg + {2'b00, patch_mean};
            frame_count_next = count_inc;
            if (count_inc >= window)
            begin
                avg = high_speed_reg ? div_window(mean_sum_next, FAST_WINDOW)
                                     : div_window(mean_sum_next, SLOW_WINDOW);
                last_average_next  = (|avg[9:8]) ? 8'hFF : avg[7:0];
                frame_count_next   = '0;
                average_ready_next = 1'b1;
                if (avg >= low_w && avg <= high_w)
                begin
                    band_next = BAND_OPTIMAL;
                end
                else if (avg >= dark_w && avg <= low_w)
                begin
                    band_next = BAND_BELOW;
                    step_r    = step_up(light_level_reg, gain_factor_reg, STEP_SMALL);
                end
                else if (avg >= high_w && avg <= shiny_w)
                begin
                    band_next = BAND_ABOVE;
                    step_r    = step_down(light_level_reg, gain_factor_reg, STEP_SMALL);
                end
                else if (avg < dark_w)
                begin
                    band_next = BAND_TOO_LOW;
                    step_r    = step_up(light_level_reg, gain_factor_reg, STEP_BIG);
                end
                else if (avg > shiny_w)
                begin
                    band_next = BAND_TOO_HIGH;
                    step_r    = step_down(light_level_reg, gain_factor_reg, STEP_BIG);
                end
                else
                begin
                    band_next = BAND_UNMATCHED;
                end
                light_level_next   = step_r.level;
                gain_factor_next   = step_r.gain;
                level_changed_next = step_r.changed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_sum_reg     <= '0;
            frame_count_reg  <= '0;
            light_level_reg  <= 7'(START_LEVEL);
            gain_factor_reg  <= 3'(START_GAIN);
            last_average_reg <= '0;
        end
        else if (in_beat)
        begin
            mean_sum_reg     <= mean_sum_next;
            frame_count_reg  <= frame_count_next;
            light_level_reg  <= light_level_next;
            gain_factor_reg  <= gain_factor_next;
            last_average_reg <= last_average_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // Payload loads only on an input beat; otherwise hold
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            led_level_reg     <= light_level_next;
            digital_gain_reg  <= gain_factor_next;
            average_ready_reg <= average_ready_next;
            frame_average_reg <= last_average_next;
            band_reg          <= band_next;
            level_changed_reg <= level_changed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign led_level     = led_level_reg;
    assign digital_gain  = digital_gain_reg;
    assign average_ready = average_ready_reg;
    assign frame_average = frame_average_reg;
    assign band          = band_reg;
    assign level_changed = level_changed_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        light_level_reg >= 7'(LEVEL_FLOOR) && light_level_reg <= 7'(LEVEL_TOP))
        else $error("light level left its range");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_factor_reg >= 3'd1 && gain_factor_reg <= 3'd4)
        else $error("gain left its range");

    a_band_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((band_reg != BAND_NONE) == average_ready_reg))
        else $error("band and average_ready disagree");

    a_changed_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && level_changed_reg) |-> (average_ready_reg &&
            (band_reg == BAND_BELOW || band_reg == BAND_ABOVE ||
             band_reg == BAND_TOO_LOW || band_reg == BAND_TOO_HIGH)))
        else $error("level changed without a stepping band");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (led_level_reg == light_level_reg && digital_gain_reg == gain_factor_reg
                     && frame_average_reg == last_average_reg))
        else $error("result does not match the updated state");

    a_window_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && average_ready_next) |=> (frame_count_reg == 3'd0))
        else $error("window did not restart after completing");

endmodule

`default_nettype wire
